@@ design/rblc_pkg.sv @@
package rblc_pkg;

    localparam int SLOT_COUNT   = 8;
    localparam int BUFFER_BYTES = 8192;
    localparam int OFFSET_BITS  = 48;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
    localparam int POS_W  = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = 32;
    localparam int RES_W  = 15;
    localparam int OC_W   = 3;

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    typedef enum logic [OC_W-1:0] {
        OC_HIT      = 3'd0,
        OC_MISS     = 3'd1,
        OC_BYPASS   = 3'd2,
        OC_FILL_OK  = 3'd3,
        OC_FILL_ERR = 3'd4,
        OC_SHORT    = 3'd5
    } t_outcome;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

@@ design/rblc_ctrl.sv @@
module rblc_ctrl
    import rblc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_cmd.exec = (r_state == S_IDLE) && i_valid;

endmodule

@@ design/rblc_dpath.sv @@
module rblc_dpath
    import rblc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic                   i_command,
    input  logic [OFFSET_BITS-1:0] i_byte_offset,
    input  logic [CNT_W-1:0]       i_byte_count,
    input  logic [SLOT_W-1:0]      i_fill_slot,
    input  logic [RES_W-1:0]       i_fill_result,
    output logic [OC_W-1:0]        o_outcome,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [POS_W-1:0]       o_position_in_buffer
);

    localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(BUFFER_BYTES);

    logic [OFFSET_BITS-1:0] r_start [SLOT_COUNT];
    logic [LEN_W-1:0]       r_len   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  r_valid;
    logic [SLOT_W-1:0]      r_order [SLOT_COUNT];
    logic [SLOT_W-1:0]      n_order [SLOT_COUNT];

    t_outcome               r_outcome;
    logic [SLOT_W-1:0]      r_slot;
    logic [POS_W-1:0]       r_pos;

    logic [OFFSET_BITS-1:0] diff [SLOT_COUNT];
    logic [LEN_W-1:0]       rem  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  hit_vec;
    logic [SLOT_COUNT-1:0]  match;
    logic [SLOT_COUNT-1:0]  after;
    logic [SLOT_W-1:0]      hit_idx;
    logic [SLOT_W-1:0]      touch;
    logic                   any_hit;
    logic                   bypass;
    logic                   fill_neg;
    logic [RES_W-2:0]       res_mag;
    logic                   fill_short;
    logic [LEN_W-1:0]       fill_len;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            diff[i]    = i_byte_offset - r_start[i];
            rem[i]     = r_len[i] - diff[i][LEN_W-1:0];
            hit_vec[i] = r_valid[i] && (i_byte_offset >= r_start[i])
                      && (diff[i] <= OFFSET_BITS'(r_len[i]))
                      && (CNT_W'(rem[i]) >= i_byte_count);
        end
        hit_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (hit_vec[i]) hit_idx = SLOT_W'(i);
        end
        any_hit = |hit_vec;
        touch   = any_hit ? hit_idx : r_order[0];

        for (int i = 0; i < SLOT_COUNT; i++) begin
            match[i] = (r_order[i] == touch);
        end
        after[0] = match[0];
        for (int i = 1; i < SLOT_COUNT; i++) begin
            after[i] = after[i-1] | match[i];
        end
        for (int i = 0; i < SLOT_COUNT - 1; i++) begin
            n_order[i] = after[i] ? r_order[i+1] : r_order[i];
        end
        n_order[SLOT_COUNT-1] = touch;
    end

    assign bypass     = i_byte_count > CNT_W'(BUFFER_BYTES);
    assign fill_neg   = i_fill_result[RES_W-1];
    assign res_mag    = i_fill_result[RES_W-2:0];
    assign fill_short = CNT_W'(res_mag) < i_byte_count;
    assign fill_len   = (CNT_W'(res_mag) > CNT_W'(BUFFER_BYTES)) ? BUF_LEN
                                                                 : LEN_W'(res_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_order[i] <= SLOT_W'(i);
            end
        end else if (i_cmd.exec) begin
            if (i_command == CMD_READ) begin
                if (!bypass) begin
                    r_order <= n_order;
                    if (!any_hit) r_valid[touch] <= 1'b0;
                end
            end else if (!fill_neg && !fill_short) begin
                r_valid[i_fill_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pos <= '0;
            if (i_command == CMD_READ) begin
                if (bypass) begin
                    r_outcome <= OC_BYPASS;
                    r_slot    <= '0;
                end else if (any_hit) begin
                    r_outcome <= OC_HIT;
                    r_slot    <= hit_idx;
                    r_pos     <= diff[hit_idx][POS_W-1:0];
                end else begin
                    r_outcome <= OC_MISS;
                    r_slot    <= touch;
                end
            end else begin
                r_slot <= i_fill_slot;
                if (fill_neg) begin
                    r_outcome <= OC_FILL_ERR;
                end else if (fill_short) begin
                    r_outcome <= OC_SHORT;
                end else begin
                    r_outcome            <= OC_FILL_OK;
                    r_start[i_fill_slot] <= i_byte_offset;
                    r_len[i_fill_slot]   <= fill_len;
                end
            end
        end
    end

    assign o_outcome            = r_outcome;
    assign o_slot               = r_slot;
    assign o_position_in_buffer = r_pos;

endmodule

@@ design/range_buffer_lru_cache_core.sv @@
// Tag and LRU replacement controller for an 8-slot read cache over file byte
// ranges. A read word either hits (lowest valid slot covering the range, made
// most recent, byte position reported), misses (least recent slot chosen,
// made most recent and invalidated), or bypasses when longer than the buffer.
// A fill completion word records a slot's start and length, or reports an
// error or short fill. One result word per input word. An input word is
// accepted in the idle cycle, all slot compares and the recency update run in
// that cycle, and the result sits in an output register until taken; the
// next word is accepted in the cycle after the result is taken.
module range_buffer_lru_cache_core
    import rblc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_command,
    input  logic [OFFSET_BITS-1:0] i_byte_offset,
    input  logic [CNT_W-1:0]       i_byte_count,
    input  logic [SLOT_W-1:0]      i_fill_slot,
    input  logic [RES_W-1:0]       i_fill_result,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OC_W-1:0]        o_outcome,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [POS_W-1:0]       o_position_in_buffer
);

    t_dp_cmd dp_cmd;

    rblc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (dp_cmd)
    );

    rblc_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .i_command            (i_command),
        .i_byte_offset        (i_byte_offset),
        .i_byte_count         (i_byte_count),
        .i_fill_slot          (i_fill_slot),
        .i_fill_result        (i_fill_result),
        .o_outcome            (o_outcome),
        .o_slot               (o_slot),
        .o_position_in_buffer (o_position_in_buffer)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while result pending");

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted word gave no result");

    a_pos_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome != OC_HIT)) |-> (o_position_in_buffer == '0))
        else $error("nonzero position on non-hit");

    a_bypass_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == OC_BYPASS)) |-> (o_slot == '0))
        else $error("bypass reports a slot");

endmodule
